// ===== hw/rtl/cossim_pkg.sv =====
package cossim_pkg;

    localparam int C_MAX_ELEMENTS = 4096;
    localparam int C_ELEM_WIDTH   = 16;

    localparam int C_FIELD_W   = 16;
    localparam int C_ELEM_W    = C_FIELD_W + 1;
    localparam int C_DOT_W     = 44;
    localparam int C_NORM_W    = 43;
    localparam int C_CNT_OUT_W = 13;
    localparam int C_EPROD_W   = 2 * C_ELEM_W;
    localparam int C_OP_W      = 33;
    localparam int C_PROD_W    = 2 * C_OP_W;
    localparam int C_NSH_W     = 30;
    localparam int C_PN_W      = 2 * C_NSH_W;
    localparam int C_SUM_W     = 120;
    localparam int C_LHS_W     = 92;
    localparam int C_ROOT_W    = 16;
    localparam int C_SH_W      = 7;

    localparam bit C_ELEM_SIGNED = (C_ELEM_WIDTH <= C_FIELD_W);
    localparam int C_SIGN_BIT    = C_ELEM_SIGNED ? C_ELEM_WIDTH - 1 : C_FIELD_W - 1;

    typedef struct packed {
        logic signed [C_FIELD_W-1:0] elem_a;
        logic signed [C_FIELD_W-1:0] elem_b;
        logic                        last_pair;
    } t_in;

    typedef struct packed {
        logic signed [C_ROOT_W-1:0]  similarity;
        logic                        zero_norm;
        logic [C_CNT_OUT_W-1:0]      pair_count;
        logic                        saturated;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_LOAD,
        S_NORM,
        S_SETUP,
        S_SEARCH,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        ACC_DOT,
        ACC_NA,
        ACC_NB
    } t_acc_sel;

    typedef struct packed {
        logic     clear;
        logic     add;
        t_acc_sel sel;
        logic     step_count;
    } t_acc_ctrl;

    // Takes the low element bits; narrower elements are sign extended,
    // wider ones leave the field value non-negative.
    function automatic logic signed [C_ELEM_W-1:0] f_elem(input logic [C_FIELD_W-1:0] raw);
        logic [C_ELEM_W-1:0] v;
        v = {1'b0, raw};
        if (C_ELEM_SIGNED) begin
            for (int i = 0; i < C_ELEM_W; i++) begin
                if (i >= C_ELEM_WIDTH) begin
                    v[i] = raw[C_SIGN_BIT];
                end
            end
        end
        return signed'(v);
    endfunction

endpackage

// ===== hw/rtl/cosine_similarity_stream.sv =====
// Streaming cosine similarity of two fixed-point vectors.
// Input channel: one element pair per transfer (elem_a, elem_b, last_pair).
// Output channel: one result per vector, sent after the pair marked last,
// carrying similarity (Q1.15), zero_norm, pair_count and saturated.
// Every pair goes through one shared 33x33 multiplier three times, and a
// new pair is taken only once the block is through with the one before.
// On the last pair the same multiplier runs the back end: the norms are
// scaled down two bits per shift step, a setup pass forms the norm product
// and the squared dot product, and the root search tests 1 to 16 candidates,
// one per root bit from the top; a vector with a zero norm skips the back end.
// The result register frees the input side: new pairs are taken while a
// result waits, and only the next result waits for the receiver to take it.
// Synchronous reset clears the accumulators and drops any pending result.
module cosine_similarity_stream #(
    parameter int MAX_ELEMENTS = cossim_pkg::C_MAX_ELEMENTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cossim_pkg::t_in    i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cossim_pkg::t_out   o_out_data
);
    import cossim_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    t_state                    r_state, n_state;
    logic [2:0]                r_step;
    logic [3:0]                r_bit;
    logic signed [C_ELEM_W-1:0] r_a, r_b;
    logic                      r_last;
    logic [C_NORM_W-1:0]       r_na, r_nb;
    logic [C_DOT_W-1:0]        r_dp;
    logic                      r_neg, r_zero, r_sat_out;
    logic [C_CNT_OUT_W-1:0]    r_cnt_out;
    logic [C_PN_W-1:0]         r_pn;
    logic [C_SUM_W-1:0]        r_xsq, n_sum, add_base;
    logic [C_LHS_W-1:0]        r_lhs;
    logic [31:0]               r_t2;
    logic [C_ROOT_W-1:0]       r_root, cand, t_odd, sim_val;
    logic                      r_out_valid;
    t_out                      r_out;

    logic                      mul_en;
    logic signed [C_OP_W-1:0]  mul_a, mul_b;
    logic signed [C_PROD_W-1:0] prod;
    logic [63:0]               pu;
    logic [C_SH_W-1:0]         add_sh;

    t_acc_ctrl                 acc_ctrl;
    logic signed [C_DOT_W-1:0] dot_acc;
    logic [C_NORM_W-1:0]       na_acc, nb_acc;
    logic [CNT_W-1:0]          cnt_acc;
    logic                      sat_acc;

    logic                      in_xfer, out_load, na_hi, nb_hi, fits;
    logic [31:0]               xl;
    logic [C_DOT_W-17:0]       xh;

    cossim_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    cossim_acc #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (acc_ctrl),
        .i_prod   (prod[C_EPROD_W-1:0]),
        .o_dot    (dot_acc),
        .o_norm_a (na_acc),
        .o_norm_b (nb_acc),
        .o_count  (cnt_acc),
        .o_sat    (sat_acc)
    );

    assign pu       = prod[63:0];
    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign na_hi    = |r_na[C_NORM_W-1:C_NSH_W];
    assign nb_hi    = |r_nb[C_NORM_W-1:C_NSH_W];
    assign xl       = {r_dp[15:0], 16'h0000};
    assign xh       = r_dp[C_DOT_W-1:16];
    assign cand     = (r_bit == 4'd15) ? 16'h8000 : (r_root | (16'd1 << r_bit));
    assign t_odd    = C_ROOT_W'({cand, 1'b0} - 17'd1);
    assign fits     = C_SUM_W'(r_lhs) <= r_xsq;
    assign add_base = (r_state == S_SEARCH) ? C_SUM_W'(r_lhs) : r_xsq;
    assign n_sum    = add_base + (C_SUM_W'(pu) << add_sh);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_step == 3'd3) begin
                    n_state = r_last ? S_LOAD : S_IDLE;
                end
            end
            S_LOAD: begin
                n_state = (na_acc == '0 || nb_acc == '0) ? S_OUT : S_NORM;
            end
            S_NORM: begin
                if (!na_hi && !nb_hi) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (r_step == 3'd4) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_step == 3'd4 && ((fits && r_bit == 4'd15) || r_bit == 4'd0)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        add_sh     = '0;
        acc_ctrl   = '{clear: 1'b0, add: 1'b0, sel: ACC_DOT, step_count: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_ACC: begin
                mul_en = (r_step < 3'd3);
                case (r_step)
                    3'd0: begin
                        mul_a = C_OP_W'(r_a);
                        mul_b = C_OP_W'(r_b);
                    end
                    3'd1: begin
                        mul_a = C_OP_W'(r_a);
                        mul_b = C_OP_W'(r_a);
                    end
                    default: begin
                        mul_a = C_OP_W'(r_b);
                        mul_b = C_OP_W'(r_b);
                    end
                endcase
                acc_ctrl.add        = (r_step != 3'd0);
                acc_ctrl.step_count = (r_step == 3'd3);
                if (r_step == 3'd2) begin
                    acc_ctrl.sel = ACC_NA;
                end else if (r_step == 3'd3) begin
                    acc_ctrl.sel = ACC_NB;
                end
            end
            S_LOAD: begin
                acc_ctrl.clear = 1'b1;
            end
            S_NORM: begin
                mul_en = 1'b0;
            end
            S_SETUP: begin
                mul_en = (r_step < 3'd4);
                case (r_step)
                    3'd0: begin
                        mul_a = C_OP_W'(r_na[C_NSH_W-1:0]);
                        mul_b = C_OP_W'(r_nb[C_NSH_W-1:0]);
                    end
                    3'd1: begin
                        mul_a = C_OP_W'(xl);
                        mul_b = C_OP_W'(xl);
                    end
                    3'd2: begin
                        mul_a = C_OP_W'(xh);
                        mul_b = C_OP_W'(xh);
                    end
                    default: begin
                        mul_a = C_OP_W'(xl);
                        mul_b = C_OP_W'(xh);
                    end
                endcase
                if (r_step == 3'd3) begin
                    add_sh = C_SH_W'(64);
                end else if (r_step == 3'd4) begin
                    add_sh = C_SH_W'(33);
                end
            end
            S_SEARCH: begin
                mul_en = (r_step < 3'd3);
                case (r_step)
                    3'd0: begin
                        mul_a = C_OP_W'(t_odd);
                        mul_b = C_OP_W'(t_odd);
                    end
                    3'd1: begin
                        mul_a = C_OP_W'(pu[31:0]);
                        mul_b = C_OP_W'(r_pn[31:0]);
                    end
                    default: begin
                        mul_a = C_OP_W'(r_t2);
                        mul_b = C_OP_W'(r_pn[C_PN_W-1:32]);
                    end
                endcase
                if (r_step == 3'd3) begin
                    add_sh = C_SH_W'(32);
                end
            end
            S_OUT: begin
                o_in_ready = 1'b0;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (r_zero) begin
            sim_val = '0;
        end else if (r_neg) begin
            sim_val = ~r_root + 16'd1;
        end else if (r_root[C_ROOT_W-1]) begin
            sim_val = 16'h7FFF;
        end else begin
            sim_val = r_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_step <= '0;
            end else if (r_state == S_SEARCH && r_step == 3'd4) begin
                r_step <= '0;
            end else if (r_state == S_ACC || r_state == S_SETUP || r_state == S_SEARCH) begin
                r_step <= r_step + 3'd1;
            end
            if (r_state == S_SETUP) begin
                r_bit <= 4'd15;
            end else if (r_state == S_SEARCH && r_step == 3'd4) begin
                r_bit <= r_bit - 4'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a    <= f_elem(i_in_data.elem_a);
            r_b    <= f_elem(i_in_data.elem_b);
            r_last <= i_in_data.last_pair;
        end
        case (r_state)
            S_LOAD: begin
                r_na      <= na_acc;
                r_nb      <= nb_acc;
                r_neg     <= dot_acc[C_DOT_W-1];
                r_dp      <= dot_acc[C_DOT_W-1] ? unsigned'(-dot_acc) : unsigned'(dot_acc);
                r_zero    <= (na_acc == '0 || nb_acc == '0);
                r_cnt_out <= C_CNT_OUT_W'(cnt_acc);
                r_sat_out <= sat_acc;
                r_xsq     <= '0;
                r_root    <= '0;
            end
            S_NORM: begin
                if (na_hi) begin
                    r_na <= r_na >> 2;
                end
                if (nb_hi) begin
                    r_nb <= r_nb >> 2;
                end
                r_dp <= r_dp >> ({1'b0, na_hi} + {1'b0, nb_hi});
            end
            S_SETUP: begin
                if (r_step == 3'd1) begin
                    r_pn <= pu[C_PN_W-1:0];
                end else if (r_step != 3'd0) begin
                    r_xsq <= n_sum;
                end
            end
            S_SEARCH: begin
                if (r_step == 3'd0) begin
                    r_lhs <= '0;
                end else if (r_step == 3'd1) begin
                    r_t2 <= pu[31:0];
                end else if (r_step == 3'd4) begin
                    if (fits) begin
                        r_root <= cand;
                    end
                end else begin
                    r_lhs <= C_LHS_W'(n_sum);
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out.similarity <= signed'(sim_val);
            r_out.zero_norm  <= r_zero;
            r_out.pair_count <= r_cnt_out;
            r_out.saturated  <= r_sat_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (cnt_acc == '0 && !sat_acc && na_acc == '0))
        else $error("accumulators not cleared after a vector");

    a_norm_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |-> (!na_hi && !nb_hi))
        else $error("norm not scaled below the search range");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> !r_root[C_ROOT_W-1])
        else $error("root search continued past full scale");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.zero_norm) |-> (o_out_data.similarity == '0))
        else $error("zero-norm result carries a nonzero similarity");
`endif

endmodule

// ===== hw/rtl/cossim_mul.sv =====
module cossim_mul (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [cossim_pkg::C_OP_W-1:0]   i_a,
    input  logic signed [cossim_pkg::C_OP_W-1:0]   i_b,
    output logic signed [cossim_pkg::C_PROD_W-1:0] o_prod
);
    import cossim_pkg::*;

    logic signed [C_PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/cossim_acc.sv =====
module cossim_acc #(
    parameter int MAX_ELEMENTS = cossim_pkg::C_MAX_ELEMENTS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  cossim_pkg::t_acc_ctrl                   i_ctrl,
    input  logic signed [cossim_pkg::C_EPROD_W-1:0] i_prod,
    output logic signed [cossim_pkg::C_DOT_W-1:0]   o_dot,
    output logic [cossim_pkg::C_NORM_W-1:0]         o_norm_a,
    output logic [cossim_pkg::C_NORM_W-1:0]         o_norm_b,
    output logic [$clog2(MAX_ELEMENTS + 1)-1:0]     o_count,
    output logic                                    o_sat
);
    import cossim_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int DSW   = C_DOT_W + 1;
    localparam int NSW   = C_NORM_W + 1;
    localparam logic signed [DSW-1:0] DOT_HI = {2'b00, {(C_DOT_W - 1){1'b1}}};
    localparam logic signed [DSW-1:0] DOT_LO = {2'b11, {(C_DOT_W - 1){1'b0}}};

    logic signed [C_DOT_W-1:0] r_dot, n_dot;
    logic [C_NORM_W-1:0]       r_na, n_na, r_nb, n_nb;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_sat, n_sat;
    logic signed [DSW-1:0]     dot_sum;
    logic [NSW-1:0]            norm_sum;
    logic [C_NORM_W-1:0]       norm_sel;

    assign dot_sum  = DSW'(r_dot) + DSW'(i_prod);
    assign norm_sel = (i_ctrl.sel == ACC_NA) ? r_na : r_nb;
    assign norm_sum = NSW'(norm_sel) + NSW'(i_prod[C_EPROD_W-2:0]);

    always_comb begin
        n_dot = r_dot;
        n_na  = r_na;
        n_nb  = r_nb;
        n_cnt = r_cnt;
        n_sat = r_sat;
        if (i_ctrl.clear) begin
            n_dot = '0;
            n_na  = '0;
            n_nb  = '0;
            n_cnt = '0;
            n_sat = 1'b0;
        end else begin
            if (i_ctrl.add) begin
                unique case (i_ctrl.sel)
                    ACC_DOT: begin
                        if (dot_sum > DOT_HI) begin
                            n_dot = DOT_HI[C_DOT_W-1:0];
                            n_sat = 1'b1;
                        end else if (dot_sum < DOT_LO) begin
                            n_dot = DOT_LO[C_DOT_W-1:0];
                            n_sat = 1'b1;
                        end else begin
                            n_dot = dot_sum[C_DOT_W-1:0];
                        end
                    end
                    ACC_NA: begin
                        n_na = norm_sum[C_NORM_W] ? '1 : norm_sum[C_NORM_W-1:0];
                        n_sat = r_sat | norm_sum[C_NORM_W];
                    end
                    ACC_NB: begin
                        n_nb = norm_sum[C_NORM_W] ? '1 : norm_sum[C_NORM_W-1:0];
                        n_sat = r_sat | norm_sum[C_NORM_W];
                    end
                    default: begin
                        n_dot = r_dot;
                    end
                endcase
            end
            if (i_ctrl.step_count) begin
                if (r_cnt >= CNT_W'(MAX_ELEMENTS)) begin
                    n_sat = 1'b1;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
            r_sat <= 1'b0;
        end else begin
            r_dot <= n_dot;
            r_na  <= n_na;
            r_nb  <= n_nb;
            r_cnt <= n_cnt;
            r_sat <= n_sat;
        end
    end

    assign o_dot    = r_dot;
    assign o_norm_a = r_na;
    assign o_norm_b = r_nb;
    assign o_count  = r_cnt;
    assign o_sat    = r_sat;

endmodule
